>>> sv/u8bmp_pkg.sv
// Shared types, codes and reset values for the UTF-8 to BMP code decoder.
package u8bmp_pkg;

    // Result kinds carried on m_tuser.
    localparam logic [1:0] KIND_DECODED  = 2'd0;
    localparam logic [1:0] KIND_BAD      = 2'd1;
    localparam logic [1:0] KIND_OVERLONG = 2'd2;
    localparam logic [1:0] KIND_EXTENDED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BAD_MARKER      = 2'd0;
    localparam logic [1:0] CFG_UNKNOWN_MARKER  = 2'd1;
    localparam logic [1:0] CFG_EXTENDED_MARKER = 2'd2;

    localparam logic [15:0] BAD_MARKER_RESET      = 16'd63;
    localparam logic [15:0] UNKNOWN_MARKER_RESET  = 16'd65533;
    localparam logic [15:0] EXTENDED_MARKER_RESET = 16'd65533;

    // Length of the open sequence; zero means no sequence is open.
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] lead;
        logic [5:0] payload;
        logic [2:0] length;
        logic [1:0] count;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]                  num;
        logic [MAX_RESULTS-1:0][15:0] code;
        logic [MAX_RESULTS-1:0][1:0]  kind;
    } result_set_t;

    typedef struct packed {
        logic [15:0] bad;
        logic [15:0] unknown;
        logic [15:0] extended;
    } markers_t;

    // Number of bad markers an open sequence gives when it is flushed.
    // A four-byte lead has already reported itself.
    function automatic logic [1:0] flush_count(input seq_state_t st);
        logic [1:0] n;
        n = 2'd0;
        if (st.length != LEN_NONE) begin
            n = st.count + ((st.length != LEN_FOUR) ? 2'd1 : 2'd0);
        end
        return n;
    endfunction

endpackage

>>> sv/utf8_to_bmp_code_decoder.sv
// Top level of the UTF-8 to BMP code decoder: stream ports, state and result buffer.
// Latency: a result beat is valid the cycle after its input byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and the
// receiver takes every beat; otherwise the next byte waits for the last beat to go.
// Reset (aresetn low, synchronous): no sequence open, result buffer empty, and the
// marker registers return to 63, 65533 and 65533.
module utf8_to_bmp_code_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_point
    output logic [1:0]  m_tuser,   // [1:0] code_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    u8bmp_pkg::seq_state_t  state_reg;
    u8bmp_pkg::seq_state_t  state_next;
    u8bmp_pkg::markers_t    markers_reg;
    u8bmp_pkg::result_set_t dec_results;

    logic [u8bmp_pkg::MAX_RESULTS-1:0][15:0] code_reg;
    logic [u8bmp_pkg::MAX_RESULTS-1:0][1:0]  kind_reg;
    logic [1:0]                              cnt_reg;

    logic load;
    logic pop;

    u8bmp_decode u_decode (
        .byte_value   (s_tdata),
        .end_of_input (s_tlast),
        .cur_state    (state_reg),
        .markers      (markers_reg),
        .next_state   (state_next),
        .results      (dec_results)
    );

    // A new byte is taken only when the buffer is empty after this edge.
    assign s_tready  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign load      = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;
    assign m_tdata   = code_reg[0];
    assign m_tuser   = kind_reg[0];
    assign m_tlast   = (cnt_reg == 2'd1);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= '0;
            cnt_reg              <= 2'd0;
            markers_reg.bad      <= u8bmp_pkg::BAD_MARKER_RESET;
            markers_reg.unknown  <= u8bmp_pkg::UNKNOWN_MARKER_RESET;
            markers_reg.extended <= u8bmp_pkg::EXTENDED_MARKER_RESET;
        end else begin
            if (load) begin
                state_reg <= state_next;
                cnt_reg   <= dec_results.num;
            end else if (pop) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    u8bmp_pkg::CFG_BAD_MARKER:      markers_reg.bad      <= cfg_data;
                    u8bmp_pkg::CFG_UNKNOWN_MARKER:  markers_reg.unknown  <= cfg_data;
                    u8bmp_pkg::CFG_EXTENDED_MARKER: markers_reg.extended <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result entries carry no reset; the count says which are live.
    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= dec_results.code;
            kind_reg <= dec_results.kind;
        end else if (pop) begin
            for (int i = 0; i < u8bmp_pkg::MAX_RESULTS - 1; i++) begin
                code_reg[i] <= code_reg[i+1];
                kind_reg[i] <= kind_reg[i+1];
            end
        end
    end

    a_load_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("byte accepted while earlier results still wait");

    a_pop_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !load && cnt_reg == 2'd2) |=> (cnt_reg == 2'd1))
        else $error("result buffer count did not step down on a beat");

    a_closed_has_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.length == u8bmp_pkg::LEN_NONE) |-> (state_reg.count == 2'd0))
        else $error("continuations counted with no sequence open");

    a_three_byte_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.length == u8bmp_pkg::LEN_THREE || state_reg.length == u8bmp_pkg::LEN_TWO)
        |-> (state_reg.count <= 2'd1))
        else $error("too many continuations buffered for an open sequence");

endmodule

>>> sv/u8bmp_decode.sv
// Combinational decode of one byte against the open sequence into up to three results.
module u8bmp_decode (
    input  logic [7:0]               byte_value,
    input  logic                     end_of_input,
    input  u8bmp_pkg::seq_state_t    cur_state,
    input  u8bmp_pkg::markers_t      markers,
    output u8bmp_pkg::seq_state_t    next_state,
    output u8bmp_pkg::result_set_t   results
);

    localparam u8bmp_pkg::seq_state_t CLOSED = '{
        lead: 8'd0, payload: 6'd0, length: u8bmp_pkg::LEN_NONE, count: 2'd0};

    logic                  is_cont;
    logic [5:0]            low;
    logic [15:0]           cp2;
    logic [15:0]           cp3;
    logic [1:0]            n_pre;
    logic                  has_prim;
    logic [15:0]           prim_code;
    logic [1:0]            prim_kind;
    logic [1:0]            n_post;
    logic [2:0]            total;
    u8bmp_pkg::seq_state_t mid_state;

    assign is_cont = (byte_value[7:6] == 2'b10);
    assign low     = byte_value[5:0];
    assign cp2     = {5'd0, cur_state.lead[4:0], low};
    assign cp3     = {cur_state.lead[3:0], cur_state.payload, low};

    always_comb begin
        n_pre     = 2'd0;
        has_prim  = 1'b0;
        prim_code = markers.bad;
        prim_kind = u8bmp_pkg::KIND_BAD;
        mid_state = cur_state;

        if (byte_value == 8'd0) begin
            n_pre     = u8bmp_pkg::flush_count(cur_state);
            mid_state = CLOSED;
        end else if (cur_state.length != u8bmp_pkg::LEN_NONE && is_cont) begin
            case (cur_state.length)
                u8bmp_pkg::LEN_TWO: begin
                    has_prim  = 1'b1;
                    mid_state = CLOSED;
                    if (cp2 < 16'h0080) begin
                        prim_code = markers.unknown;
                        prim_kind = u8bmp_pkg::KIND_OVERLONG;
                    end else begin
                        prim_code = cp2;
                        prim_kind = u8bmp_pkg::KIND_DECODED;
                    end
                end
                u8bmp_pkg::LEN_THREE: begin
                    if (cur_state.count == 2'd0) begin
                        mid_state.payload = low;
                        mid_state.count   = 2'd1;
                    end else begin
                        has_prim  = 1'b1;
                        mid_state = CLOSED;
                        if (cp3 < 16'h0800) begin
                            prim_code = markers.unknown;
                            prim_kind = u8bmp_pkg::KIND_OVERLONG;
                        end else if (cp3 >= 16'hD800 && cp3 <= 16'hDFFF) begin
                            prim_code = markers.extended;
                            prim_kind = u8bmp_pkg::KIND_EXTENDED;
                        end else begin
                            prim_code = cp3;
                            prim_kind = u8bmp_pkg::KIND_DECODED;
                        end
                    end
                end
                default: begin
                    // Four-byte sequence: continuations are counted and dropped.
                    if (cur_state.count < 2'd2) begin
                        mid_state.count = cur_state.count + 2'd1;
                    end else begin
                        mid_state = CLOSED;
                    end
                end
            endcase
        end else begin
            // Any open sequence is broken by this byte, which then starts anew.
            n_pre     = u8bmp_pkg::flush_count(cur_state);
            mid_state = CLOSED;
            if (byte_value[7] == 1'b0) begin
                has_prim  = 1'b1;
                prim_code = {8'd0, byte_value};
                prim_kind = u8bmp_pkg::KIND_DECODED;
            end else if (byte_value[7:5] == 3'b110) begin
                mid_state.lead   = byte_value;
                mid_state.length = u8bmp_pkg::LEN_TWO;
            end else if (byte_value[7:4] == 4'b1110) begin
                mid_state.lead   = byte_value;
                mid_state.length = u8bmp_pkg::LEN_THREE;
            end else if (byte_value[7:3] == 5'b11110) begin
                has_prim         = 1'b1;
                prim_code        = markers.extended;
                prim_kind        = u8bmp_pkg::KIND_EXTENDED;
                mid_state.lead   = byte_value;
                mid_state.length = u8bmp_pkg::LEN_FOUR;
            end else begin
                has_prim = 1'b1;
            end
        end
    end

    // The end flag flushes whatever this byte left open; a zero byte has closed it already.
    always_comb begin
        n_post     = 2'd0;
        next_state = mid_state;
        if (end_of_input && byte_value != 8'd0) begin
            n_post     = u8bmp_pkg::flush_count(mid_state);
            next_state = CLOSED;
        end
    end

    assign total = {1'b0, n_pre} + {2'd0, has_prim} + {1'b0, n_post};

    always_comb begin
        results.num = (total > 3'd3) ? 2'd3 : total[1:0];
        for (int i = 0; i < u8bmp_pkg::MAX_RESULTS; i++) begin
            if (has_prim && i == int'(n_pre)) begin
                results.code[i] = prim_code;
                results.kind[i] = prim_kind;
            end else begin
                results.code[i] = markers.bad;
                results.kind[i] = u8bmp_pkg::KIND_BAD;
            end
        end
    end

endmodule

>>> test/utf8_to_bmp_code_decoder_tb.sv
// Self-checking testbench for the UTF-8 to BMP code decoder: directed table, random runs.
module utf8_to_bmp_code_decoder_tb;
    import u8bmp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BYTES = 68;
    localparam int PRESSURE_BYTES = 30;
    localparam int MAX_PRINTED = 20;
    // Index past the last marker register; the block ignores writes to it.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [15:0] code;
        logic [1:0]  kind;
        logic        last;
    } code_beat_t;

    typedef struct packed {
        logic [7:0]  byte_val;
        logic        end_flag;
        logic        typed;
        logic [15:0] code;
        logic [1:0]  kind;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    utf8_to_bmp_code_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Decoder model state and marker copies.
    logic [7:0]  open_lead;
    logic [5:0]  open_payload [2];
    logic [2:0]  open_len;
    logic [1:0]  open_cnt;
    logic [15:0] mark_bad;
    logic [15:0] mark_unknown;
    logic [15:0] mark_ext;

    code_beat_t step_codes [MAX_RESULTS];
    int         step_n;
    code_beat_t code_q [$];
    code_beat_t want_beat;
    dir_row_t   dir_tab [$];

    int errors;
    int bytes_sent;
    int beats_seen;
    int cfg_writes;
    int quiet;
    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) $display("MISMATCH: %0s", msg);
    endtask

    task automatic put_code(input logic [15:0] c, input logic [1:0] k);
        if (step_n < MAX_RESULTS) begin
            step_codes[step_n].code = c;
            step_codes[step_n].kind = k;
            step_codes[step_n].last = 1'b0;
            step_n++;
        end
    endtask

    task automatic close_open;
        open_len = LEN_NONE;
        open_cnt = 2'd0;
        open_lead = 8'd0;
    endtask

    // A four-byte lead has already reported itself, so only its buffered bytes count.
    task automatic flush_open;
        int i;
        if (open_len != LEN_NONE) begin
            if (open_len != LEN_FOUR) put_code(mark_bad, KIND_BAD);
            for (i = 0; i < int'(open_cnt) && i < 2; i++) put_code(mark_bad, KIND_BAD);
            close_open();
        end
    endtask

    task automatic take_lead(input logic [7:0] b);
        if (b < 8'h80) begin
            put_code({8'd0, b}, KIND_DECODED);
        end else if ((b & 8'hE0) == 8'hC0) begin
            open_lead = b;
            open_len = LEN_TWO;
            open_cnt = 2'd0;
        end else if ((b & 8'hF0) == 8'hE0) begin
            open_lead = b;
            open_len = LEN_THREE;
            open_cnt = 2'd0;
        end else if ((b & 8'hF8) == 8'hF0) begin
            put_code(mark_ext, KIND_EXTENDED);
            open_lead = b;
            open_len = LEN_FOUR;
            open_cnt = 2'd0;
        end else begin
            put_code(mark_bad, KIND_BAD);
        end
    endtask

    task automatic take_cont(input logic [7:0] b);
        logic [15:0] cp;
        if (open_len == LEN_TWO) begin
            cp = {5'd0, open_lead[4:0], b[5:0]};
            if (cp < 16'h0080) put_code(mark_unknown, KIND_OVERLONG);
            else put_code(cp, KIND_DECODED);
            close_open();
        end else if (open_len == LEN_THREE) begin
            if (open_cnt == 2'd0) begin
                open_payload[0] = b[5:0];
                open_cnt = 2'd1;
            end else begin
                cp = {open_lead[3:0], open_payload[0], b[5:0]};
                if (cp < 16'h0800) put_code(mark_unknown, KIND_OVERLONG);
                else if (cp >= 16'hD800 && cp <= 16'hDFFF) put_code(mark_ext, KIND_EXTENDED);
                else put_code(cp, KIND_DECODED);
                close_open();
            end
        end else begin
            // Four-byte sequence: buffer two continuations, swallow the third.
            if (open_cnt < 2'd2) begin
                open_payload[open_cnt[0]] = b[5:0];
                open_cnt = open_cnt + 2'd1;
            end else begin
                close_open();
            end
        end
    endtask

    task automatic decode_step(input logic [7:0] b, input logic end_flag);
        step_n = 0;
        if (b == 8'd0) begin
            flush_open();
        end else begin
            if (open_len != LEN_NONE && b[7:6] == 2'b10) begin
                take_cont(b);
            end else begin
                flush_open();
                take_lead(b);
            end
            if (end_flag) flush_open();
        end
        if (step_n > 0) step_codes[step_n-1].last = 1'b1;
    endtask

    // Entered and left at a falling edge; the beat is predicted after it is taken.
    task automatic send_byte(input logic [7:0] b, input logic end_flag, input logic typed,
                             input logic [15:0] t_code, input logic [1:0] t_kind);
        int i;
        code_beat_t typed_beat;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = end_flag;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
        decode_step(b, end_flag);
        if (typed) begin
            typed_beat.code = t_code;
            typed_beat.kind = t_kind;
            typed_beat.last = 1'b1;
            code_q.push_back(typed_beat);
        end else begin
            for (i = 0; i < step_n; i++) code_q.push_back(step_codes[i]);
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_byte(b, ($urandom_range(0, 19) == 0), 1'b0, 16'd0, KIND_DECODED);
    endtask

    function automatic logic [7:0] pick_lead(input int len);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (len == 2) pick_lead = 8'hC0 | (r & 8'h1F);
        else if (len == 3) pick_lead = (r[7:6] == 2'b00) ? 8'hED : (8'hE0 | (r & 8'h0F));
        else pick_lead = 8'hF0 | (r & 8'h07);
    endfunction

    // Mostly well-formed sequences; the rest are cut short, stray or zero bytes.
    task automatic send_random_run;
        int pick;
        int len;
        int k;
        int conts;
        logic [7:0] r;
        pick = $urandom_range(0, 99);
        r = 8'($urandom_range(0, 255));
        if (pick < 30) begin
            send_plain((r & 8'h7F) | 8'h01);
        end else if (pick < 90) begin
            if (pick < 50) len = 2;
            else if (pick < 70) len = 3;
            else if (pick < 80) len = 4;
            else len = $urandom_range(2, 4);
            conts = (pick < 80) ? len - 1 : $urandom_range(0, len - 2);
            send_plain(pick_lead(len));
            for (k = 0; k < conts; k++) begin
                r = 8'($urandom_range(0, 63));
                send_plain(8'h80 | r);
            end
        end else if (pick < 96) begin
            send_plain(r);
        end else begin
            send_plain(8'd0);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_writes++;
        case (idx)
            CFG_BAD_MARKER:      mark_bad = val;
            CFG_UNKNOWN_MARKER:  mark_unknown = val;
            CFG_EXTENDED_MARKER: mark_ext = val;
            default: ;
        endcase
    endtask

    task automatic set_markers(input logic [15:0] bad, input logic [15:0] unk,
                               input logic [15:0] ext, input logic poke_unused);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        write_reg(CFG_BAD_MARKER, bad);
        write_reg(CFG_UNKNOWN_MARKER, unk);
        write_reg(CFG_EXTENDED_MARKER, ext);
        if (poke_unused) write_reg(CFG_UNUSED_INDEX, junk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained;
        while (code_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic dir_row_t row(input logic [7:0] b, input logic e, input logic typed,
                                     input logic [15:0] c, input logic [1:0] k);
        row.byte_val = b;
        row.end_flag = e;
        row.typed = typed;
        row.code = c;
        row.kind = k;
    endfunction

    // Receiver: random stalls, plus a long hold-off counted here when one is requested.
    initial begin
        m_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (code_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat code %h kind %0d last %0d",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                want_beat = code_q.pop_front();
                if (m_tdata !== want_beat.code || m_tuser !== want_beat.kind ||
                    m_tlast !== want_beat.last)
                    report_mismatch($sformatf(
                        "beat %0d got code %h kind %0d last %0d, want code %h kind %0d last %0d",
                        beats_seen, m_tdata, m_tuser, m_tlast,
                        want_beat.code, want_beat.kind, want_beat.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                         quiet, code_q.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        int start;
        int send_tab [4];
        int stall_tab [4];
        dir_row_t r;

        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BAD_MARKER;
        cfg_data = 16'd0;
        errors = 0;
        bytes_sent = 0;
        beats_seen = 0;
        cfg_writes = 0;
        quiet = 0;
        hold_req = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        send_tab = '{0, 78, 0, 11};
        stall_tab = '{0, 0, 78, 11};
        mark_bad = BAD_MARKER_RESET;
        mark_unknown = UNKNOWN_MARKER_RESET;
        mark_ext = EXTENDED_MARKER_RESET;
        open_payload[0] = 6'd0;
        open_payload[1] = 6'd0;
        close_open();

        // Stray bytes, ASCII extremes, overlong and maximal forms, surrogate, four-byte
        // swallow, broken sequence, truncation by the end flag, and flush by a zero byte.
        dir_tab.push_back(row(8'h80, 1'b0, 1'b1, BAD_MARKER_RESET, KIND_BAD));
        dir_tab.push_back(row(8'h01, 1'b0, 1'b1, 16'h0001, KIND_DECODED));
        dir_tab.push_back(row(8'h7F, 1'b0, 1'b1, 16'h007F, KIND_DECODED));
        dir_tab.push_back(row(8'hFF, 1'b0, 1'b1, BAD_MARKER_RESET, KIND_BAD));
        dir_tab.push_back(row(8'hF8, 1'b1, 1'b1, BAD_MARKER_RESET, KIND_BAD));
        dir_tab.push_back(row(8'hC0, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h80, 1'b0, 1'b1, UNKNOWN_MARKER_RESET, KIND_OVERLONG));
        dir_tab.push_back(row(8'hDF, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hBF, 1'b0, 1'b1, 16'h07FF, KIND_DECODED));
        dir_tab.push_back(row(8'hE0, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h80, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h80, 1'b0, 1'b1, UNKNOWN_MARKER_RESET, KIND_OVERLONG));
        dir_tab.push_back(row(8'hEF, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hBF, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hBF, 1'b0, 1'b1, 16'hFFFF, KIND_DECODED));
        dir_tab.push_back(row(8'hED, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hA0, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h80, 1'b0, 1'b1, EXTENDED_MARKER_RESET, KIND_EXTENDED));
        dir_tab.push_back(row(8'hF4, 1'b0, 1'b1, EXTENDED_MARKER_RESET, KIND_EXTENDED));
        dir_tab.push_back(row(8'h8F, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hBF, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hBF, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hE2, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h82, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h41, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'hC3, 1'b1, 1'b1, BAD_MARKER_RESET, KIND_BAD));
        dir_tab.push_back(row(8'hE2, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h82, 1'b0, 1'b0, 16'd0, KIND_DECODED));
        dir_tab.push_back(row(8'h00, 1'b0, 1'b0, 16'd0, KIND_DECODED));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            send_byte(r.byte_val, r.end_flag, r.typed, r.code, r.kind);
        end
        s_tvalid = 1'b0;
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_markers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 1'b0);
                1: set_markers(16'h0000, 16'h0000, 16'h0000, 1'b0);
                2: set_markers(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                default: set_markers(16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)), 1'b1);
            endcase
            send_idle_pct = send_tab[ph];
            stall_pct = stall_tab[ph];
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_random_run();
            s_tvalid = 1'b0;
            wait_drained();
        end

        // Back-pressure: the receiver holds off while bytes keep coming, so the
        // result buffer fills and the input stalls.
        set_markers(BAD_MARKER_RESET, UNKNOWN_MARKER_RESET, EXTENDED_MARKER_RESET, 1'b0);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = HOLD_CYCLES;
        start = bytes_sent;
        while (bytes_sent - start < PRESSURE_BYTES) send_random_run();
        s_tvalid = 1'b0;
        wait_drained();
        repeat (8) @(negedge aclk);

        $display("Covered %0d input bytes and %0d result beats across %0d register writes,",
                 bytes_sent, beats_seen, cfg_writes);
        $display("four idle and stall mixes, marker extremes and one long receiver hold-off.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/u8bmp_pkg.sv
sv/u8bmp_decode.sv
sv/utf8_to_bmp_code_decoder.sv
test/utf8_to_bmp_code_decoder_tb.sv
